### design/pts_pkg.sv
`default_nettype none
package pts_pkg;

    localparam logic [1:0] OP_CREATE   = 2'd0;
    localparam logic [1:0] OP_EXIT     = 2'd1;
    localparam logic [1:0] OP_SCHEDULE = 2'd2;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SCAN,
        CMD_CREATE,
        CMD_ENQUEUE,
        CMD_REQUEUE,
        CMD_PICK,
        CMD_DEQ_RD,
        CMD_DEQUEUE,
        CMD_EX_RD,
        CMD_EX_CMP,
        CMD_UL_RD,
        CMD_UL_LATCH,
        CMD_UL_CHK,
        CMD_WALK_RD,
        CMD_WALK,
        CMD_RUN_RD,
        CMD_FINISH
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       free_hit;
        logic       scan_last;
        logic       id_hit;
        logic       hit_running;
        logic       run_valid;
        logic       any_ready;
        logic       ul_done;
        logic       at_tail;
        logic       walk_hit;
    } t_stat;

endpackage
`default_nettype wire

### design/pts_ctrl.sv
`default_nettype none
module pts_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire logic [1:0]    i_op,
    input  wire pts_pkg::t_stat i_stat,
    output logic               busy,
    output pts_pkg::t_cmd      o_cmd
);
    import pts_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_CR_SCAN, S_CR_WRITE, S_ENQ, S_SC_REQ, S_PICK, S_DEQ_RD, S_DEQ,
        S_EX_RD, S_EX_CMP, S_UL_RD, S_UL_LATCH, S_UL_CHK, S_WALK_RD, S_WALK,
        S_RUN_RD, S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;

    assign busy = r_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd = CMD_LOAD;
                    case (i_op)
                        OP_CREATE:   n_state = S_CR_SCAN;
                        OP_EXIT:     n_state = S_EX_RD;
                        OP_SCHEDULE: n_state = S_SC_REQ;
                        default:     n_state = S_RUN_RD;
                    endcase
                end
            end
            S_CR_SCAN: begin
                o_cmd = CMD_SCAN;
                if (i_stat.free_hit) n_state = S_CR_WRITE;
                else if (i_stat.scan_last) n_state = S_RUN_RD;
            end
            S_CR_WRITE: begin
                o_cmd   = CMD_CREATE;
                n_state = S_ENQ;
            end
            S_ENQ: begin
                o_cmd   = CMD_ENQUEUE;
                n_state = (i_stat.op == OP_SCHEDULE) ? S_PICK : S_RUN_RD;
            end
            S_SC_REQ: begin
                o_cmd   = CMD_REQUEUE;
                n_state = i_stat.run_valid ? S_ENQ : S_PICK;
            end
            S_PICK: begin
                o_cmd   = CMD_PICK;
                n_state = i_stat.any_ready ? S_DEQ_RD : S_RUN_RD;
            end
            S_DEQ_RD: begin
                o_cmd   = CMD_DEQ_RD;
                n_state = S_DEQ;
            end
            S_DEQ: begin
                o_cmd   = CMD_DEQUEUE;
                n_state = S_RUN_RD;
            end
            S_EX_RD: begin
                o_cmd   = CMD_EX_RD;
                n_state = S_EX_CMP;
            end
            S_EX_CMP: begin
                o_cmd = CMD_EX_CMP;
                if (i_stat.id_hit) n_state = i_stat.hit_running ? S_PICK : S_UL_RD;
                else if (i_stat.scan_last) n_state = S_RUN_RD;
                else n_state = S_EX_RD;
            end
            S_UL_RD: begin
                o_cmd   = CMD_UL_RD;
                n_state = S_UL_LATCH;
            end
            S_UL_LATCH: begin
                o_cmd   = CMD_UL_LATCH;
                n_state = S_UL_CHK;
            end
            S_UL_CHK: begin
                o_cmd   = CMD_UL_CHK;
                n_state = i_stat.ul_done ? S_RUN_RD : S_WALK_RD;
            end
            S_WALK_RD: begin
                o_cmd   = CMD_WALK_RD;
                n_state = i_stat.at_tail ? S_RUN_RD : S_WALK;
            end
            S_WALK: begin
                o_cmd   = CMD_WALK;
                n_state = i_stat.walk_hit ? S_RUN_RD : S_WALK_RD;
            end
            S_RUN_RD: begin
                o_cmd   = CMD_RUN_RD;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                o_cmd   = CMD_FINISH;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

endmodule
`default_nettype wire

### design/pts_dp.sv
`default_nettype none
module pts_dp #(
    parameter int NUM_SLOTS    = 16,
    parameter int TOP_PRIORITY = 7,
    parameter int ID_WIDTH     = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire pts_pkg::t_cmd i_cmd,
    input  wire logic [1:0]    i_op,
    input  wire logic [3:0]    i_prio,
    input  wire logic [15:0]   i_task_id,
    output pts_pkg::t_stat     o_stat,
    output logic               o_done,
    output logic [1:0]         o_status,
    output logic [15:0]        o_new_id,
    output logic [15:0]        o_running_id,
    output logic               o_running_valid
);
    import pts_pkg::*;

    localparam int SW = $clog2(NUM_SLOTS);
    localparam int NQ = TOP_PRIORITY + 1;
    localparam int PW = $clog2(NQ);

    logic [ID_WIDTH-1:0] mem_id   [NUM_SLOTS];
    logic [PW-1:0]       mem_prio [NUM_SLOTS];
    logic [SW-1:0]       mem_link [NUM_SLOTS];

    logic [ID_WIDTH-1:0] r_rd_id;
    logic [PW-1:0]       r_rd_prio;
    logic [SW-1:0]       r_rd_link;

    logic [NUM_SLOTS-1:0] r_slot_vld;
    logic [SW-1:0]        r_head [NQ];
    logic [SW-1:0]        r_tail [NQ];
    logic [NQ-1:0]        r_nonempty;

    logic [1:0]          r_op;
    logic [3:0]          r_prio_in;
    logic [15:0]         r_tid;
    logic [SW-1:0]       r_scan, r_s, r_prev, r_slink, r_run_slot;
    logic [PW-1:0]       r_p, r_run_prio;
    logic                r_run_vld;
    logic [ID_WIDTH-1:0] r_id_ctr, n_id_ctr;
    logic [1:0]          r_status;
    logic [ID_WIDTH-1:0] r_new_id;

    logic [SW-1:0] rd_addr, head_p, tail_p, link_waddr, link_wdata;
    logic          ne_p, link_we;
    logic [PW-1:0] clamp_p, pick_p;
    logic [31:0]   wide_id, wide_new;

    assign head_p = r_head[r_p];
    assign tail_p = r_tail[r_p];
    assign ne_p   = r_nonempty[r_p];

    assign clamp_p = (r_prio_in > 4'(TOP_PRIORITY)) ? PW'(TOP_PRIORITY) : PW'(r_prio_in);

    always_comb begin
        n_id_ctr = r_id_ctr + ID_WIDTH'(1);
        if (n_id_ctr == '0) n_id_ctr = ID_WIDTH'(1);
    end

    // Highest non-empty queue wins.
    always_comb begin
        pick_p = '0;
        for (int q = 0; q < NQ; q++) begin
            if (r_nonempty[q]) pick_p = PW'(q);
        end
    end

    always_comb begin
        case (i_cmd)
            CMD_UL_RD:   rd_addr = r_s;
            CMD_DEQ_RD:  rd_addr = head_p;
            CMD_WALK_RD: rd_addr = r_prev;
            CMD_RUN_RD:  rd_addr = r_run_slot;
            default:     rd_addr = r_scan;
        endcase
    end

    always_comb begin
        link_we    = 1'b0;
        link_waddr = tail_p;
        link_wdata = r_s;
        if (i_cmd == CMD_ENQUEUE && ne_p) begin
            link_we = 1'b1;
        end else if (i_cmd == CMD_WALK && r_rd_link == r_s) begin
            link_we    = 1'b1;
            link_waddr = r_prev;
            link_wdata = r_slink;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_CREATE) begin
            mem_id[r_scan]   <= r_id_ctr;
            mem_prio[r_scan] <= clamp_p;
        end
        if (link_we) mem_link[link_waddr] <= link_wdata;
        r_rd_id   <= mem_id[rd_addr];
        r_rd_prio <= mem_prio[rd_addr];
        r_rd_link <= mem_link[rd_addr];
    end

    assign wide_id  = 32'(r_rd_id);
    assign wide_new = 32'(r_new_id);

    always_comb begin
        o_stat.op          = r_op;
        o_stat.free_hit    = !r_slot_vld[r_scan];
        o_stat.scan_last   = (r_scan == SW'(NUM_SLOTS - 1));
        o_stat.id_hit      = r_slot_vld[r_scan] && (wide_id == 32'(r_tid));
        o_stat.hit_running = r_run_vld && (r_run_slot == r_scan);
        o_stat.run_valid   = r_run_vld;
        o_stat.any_ready   = |r_nonempty;
        o_stat.ul_done     = !ne_p || (head_p == r_s);
        o_stat.at_tail     = (r_prev == tail_p);
        o_stat.walk_hit    = (r_rd_link == r_s);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_vld <= '0;
            r_nonempty <= '0;
            r_run_vld  <= 1'b0;
            r_id_ctr   <= ID_WIDTH'(1);
            o_done     <= 1'b0;
            for (int q = 0; q < NQ; q++) begin
                r_head[q] <= '0;
                r_tail[q] <= '0;
            end
        end else begin
            o_done <= 1'b0;
            case (i_cmd)
                CMD_LOAD: begin
                    r_op      <= i_op;
                    r_prio_in <= i_prio;
                    r_tid     <= i_task_id;
                    r_scan    <= '0;
                    r_status  <= ST_OK;
                    r_new_id  <= '0;
                end
                CMD_SCAN: begin
                    if (r_slot_vld[r_scan]) begin
                        if (r_scan == SW'(NUM_SLOTS - 1)) r_status <= ST_FULL;
                        else r_scan <= r_scan + SW'(1);
                    end
                end
                CMD_CREATE: begin
                    r_slot_vld[r_scan] <= 1'b1;
                    r_s      <= r_scan;
                    r_p      <= clamp_p;
                    r_new_id <= r_id_ctr;
                    r_id_ctr <= n_id_ctr;
                end
                CMD_ENQUEUE: begin
                    r_tail[r_p] <= r_s;
                    if (!ne_p) begin
                        r_head[r_p]     <= r_s;
                        r_nonempty[r_p] <= 1'b1;
                    end
                end
                CMD_REQUEUE: begin
                    r_s       <= r_run_slot;
                    r_p       <= r_run_prio;
                    r_run_vld <= 1'b0;
                end
                CMD_PICK: r_p <= pick_p;
                CMD_DEQUEUE: begin
                    if (head_p == tail_p) r_nonempty[r_p] <= 1'b0;
                    else r_head[r_p] <= r_rd_link;
                    r_run_slot <= head_p;
                    r_run_prio <= r_p;
                    r_run_vld  <= 1'b1;
                end
                CMD_EX_CMP: begin
                    if (o_stat.id_hit) begin
                        r_slot_vld[r_scan] <= 1'b0;
                        r_s <= r_scan;
                        if (o_stat.hit_running) r_run_vld <= 1'b0;
                    end else if (r_scan == SW'(NUM_SLOTS - 1)) begin
                        r_status <= ST_NOT_FOUND;
                    end else begin
                        r_scan <= r_scan + SW'(1);
                    end
                end
                CMD_UL_LATCH: begin
                    r_p     <= r_rd_prio;
                    r_slink <= r_rd_link;
                end
                CMD_UL_CHK: begin
                    if (ne_p) begin
                        if (head_p == r_s) begin
                            if (head_p == tail_p) r_nonempty[r_p] <= 1'b0;
                            else r_head[r_p] <= r_slink;
                        end else begin
                            r_prev <= head_p;
                        end
                    end
                end
                CMD_WALK: begin
                    if (r_rd_link == r_s) begin
                        if (tail_p == r_s) r_tail[r_p] <= r_prev;
                    end else begin
                        r_prev <= r_rd_link;
                    end
                end
                CMD_FINISH: begin
                    o_done          <= 1'b1;
                    o_status        <= r_status;
                    o_new_id        <= wide_new[15:0];
                    o_running_id    <= r_run_vld ? wide_id[15:0] : 16'd0;
                    o_running_valid <= r_run_vld;
                end
                default: ;
            endcase
        end
    end

    // The running task always owns an occupied slot.
    a_run_slot_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_vld |-> r_slot_vld[r_run_slot])
        else $error("running task slot is free");

    a_id_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_id_ctr != '0)
        else $error("id counter reached zero");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_run_not_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == CMD_DEQUEUE) |=> r_run_vld)
        else $error("dispatch did not mark a running task");

endmodule
`default_nettype wire

### design/priority_task_scheduler_core.sv
`default_nettype none
// Fixed-priority task scheduler with FIFO ready queues per priority level.
// Issue an operation by raising start with op, prio and task_id while busy is
// low; the transfer happens on that clock edge and busy is high from that edge
// until the result is shown.
// op 0 creates a task in the lowest free slot, op 1 exits the task holding
// task_id, op 2 requeues the running task and dispatches the highest ready one.
// Each operation returns exactly one result: o_done is high for one cycle with
// o_status, o_new_id, o_running_id and o_running_valid. The receiver cannot
// stall; results must be taken in that cycle.
// Operation length depends on the one-slot-per-step search (create, exit) and,
// for exit, on the linked-list walk over the slot memory; schedule needs
// neither.
// A new operation can be started in the cycle o_done is shown.
// Reset (synchronous, active low) empties all slots and queues, clears the
// running task and sets the next id to 1; no clearing pass is needed.
module priority_task_scheduler_core #(
    parameter int NUM_SLOTS    = 16,
    parameter int TOP_PRIORITY = 7,
    parameter int ID_WIDTH     = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic [1:0]  i_op,
    input  wire logic [3:0]  i_prio,
    input  wire logic [15:0] i_task_id,
    output logic             busy,
    output logic             o_done,
    output logic [1:0]       o_status,
    output logic [15:0]      o_new_id,
    output logic [15:0]      o_running_id,
    output logic             o_running_valid
);
    import pts_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    pts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_op    (i_op),
        .i_stat  (stat),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    pts_dp #(
        .NUM_SLOTS    (NUM_SLOTS),
        .TOP_PRIORITY (TOP_PRIORITY),
        .ID_WIDTH     (ID_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_op            (i_op),
        .i_prio          (i_prio),
        .i_task_id       (i_task_id),
        .o_stat          (stat),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_new_id        (o_new_id),
        .o_running_id    (o_running_id),
        .o_running_valid (o_running_valid)
    );

endmodule
`default_nettype wire

### sim/tb.sv
module tb;
    import pts_pkg::*;

    localparam int N_SLOTS  = 16;
    localparam int TOP_PRI  = 7;
    localparam int N_RANDOM = 850;
    localparam int MAX_CYC  = 1000000;

    typedef struct {
        logic [1:0]  op;
        logic [3:0]  prio;
        logic [15:0] tid;
        bit          drain;
        bit          typed;
        logic [1:0]  st;
        logic [15:0] nid;
        logic [15:0] rid;
        logic        rv;
    } t_cmd_row;

    typedef struct {
        logic [1:0]  st;
        logic [15:0] nid;
        logic [15:0] rid;
        logic        rv;
    } t_sched_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  i_op = OP_SCHEDULE;
    logic [3:0]  i_prio = '0;
    logic [15:0] i_task_id = '0;
    logic        busy, o_done, o_running_valid;
    logic [1:0]  o_status;
    logic [15:0] o_new_id, o_running_id;

    priority_task_scheduler_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_op(i_op), .i_prio(i_prio),
        .i_task_id(i_task_id), .busy(busy), .o_done(o_done), .o_status(o_status),
        .o_new_id(o_new_id), .o_running_id(o_running_id), .o_running_valid(o_running_valid)
    );

    always #10 i_clk = ~i_clk;

    // Shadow copy of the scheduler state.
    logic [15:0] slot_id  [N_SLOTS];
    logic [2:0]  slot_pri [N_SLOTS];
    logic [3:0]  slot_nxt [N_SLOTS];
    logic [3:0]  q_head   [TOP_PRI+1];
    logic [3:0]  q_tail   [TOP_PRI+1];
    logic [7:0]  q_ready;
    logic [3:0]  run_slot;
    bit          run_ok;
    logic [15:0] next_id;

    t_cmd_row   dir_rows[$];
    t_sched_res pending_q[$];
    t_cmd_row   cur;
    int         errors = 0;
    int         issued = 0;
    int         gap = 0;
    int         cycles = 0;

    task automatic report(input string msg);
        $display("tb mismatch: %s", msg);
        errors++;
    endtask

    task automatic queue_push(input logic [3:0] s);
        logic [2:0] p;
        p = slot_pri[s];
        if (q_ready[p]) begin
            slot_nxt[q_tail[p]] = s;
            q_tail[p] = s;
        end else begin
            q_head[p] = s;
            q_tail[p] = s;
            q_ready[p] = 1'b1;
        end
    endtask

    task automatic queue_pop(input logic [2:0] p, output logic [3:0] h);
        h = q_head[p];
        if (h == q_tail[p]) q_ready[p] = 1'b0;
        else q_head[p] = slot_nxt[h];
    endtask

    task automatic queue_unlink(input logic [3:0] s);
        logic [2:0] p;
        logic [3:0] prev, nxt, dummy;
        p = slot_pri[s];
        if (!q_ready[p]) return;
        if (q_head[p] == s) begin
            queue_pop(p, dummy);
            return;
        end
        prev = q_head[p];
        for (int k = 0; k < N_SLOTS; k++) begin
            if (prev == q_tail[p]) return;
            nxt = slot_nxt[prev];
            if (nxt == s) begin
                slot_nxt[prev] = slot_nxt[s];
                if (q_tail[p] == s) q_tail[p] = prev;
                return;
            end
            prev = nxt;
        end
    endtask

    task automatic dispatch();
        if (run_ok) queue_push(run_slot);
        run_ok = 0;
        for (int p = TOP_PRI; p >= 0; p--) begin
            if (q_ready[p]) begin
                queue_pop(p[2:0], run_slot);
                run_ok = 1;
                break;
            end
        end
    endtask

    task automatic sched_reset();
        for (int s = 0; s < N_SLOTS; s++) begin
            slot_id[s] = '0;
            slot_pri[s] = '0;
            slot_nxt[s] = '0;
        end
        for (int p = 0; p <= TOP_PRI; p++) begin
            q_head[p] = '0;
            q_tail[p] = '0;
        end
        q_ready = '0;
        run_slot = '0;
        run_ok = 0;
        next_id = 16'd1;
    endtask

    task automatic sched_predict(input t_cmd_row c, output t_sched_res r);
        int s;
        r.st = ST_OK;
        r.nid = '0;
        if (c.op == OP_CREATE) begin
            for (s = 0; s < N_SLOTS; s++) if (slot_id[s] == 0) break;
            if (s == N_SLOTS) begin
                r.st = ST_FULL;
            end else begin
                slot_id[s] = next_id;
                slot_pri[s] = (c.prio > TOP_PRI) ? 3'(TOP_PRI) : c.prio[2:0];
                r.nid = next_id;
                next_id = next_id + 16'd1;
                if (next_id == 0) next_id = 16'd1;
                queue_push(s[3:0]);
            end
        end else if (c.op == OP_EXIT) begin
            for (s = 0; s < N_SLOTS; s++) if (slot_id[s] != 0 && slot_id[s] == c.tid) break;
            if (s == N_SLOTS) begin
                r.st = ST_NOT_FOUND;
            end else begin
                slot_id[s] = '0;
                if (run_ok && run_slot == s) begin
                    run_ok = 0;
                    slot_pri[s] = '0;
                    dispatch();
                end else begin
                    queue_unlink(s[3:0]);
                    slot_pri[s] = '0;
                end
            end
        end else if (c.op == OP_SCHEDULE) begin
            dispatch();
        end
        r.rv = run_ok;
        r.rid = run_ok ? slot_id[run_slot] : 16'd0;
    endtask

    function automatic t_cmd_row mk(input logic [1:0] op, input logic [3:0] prio,
                                    input logic [15:0] tid);
        t_cmd_row c;
        c = '{op: op, prio: prio, tid: tid, drain: 0, typed: 0,
              st: ST_OK, nid: 0, rid: 0, rv: 0};
        return c;
    endfunction

    function automatic t_cmd_row typed_row(input t_cmd_row c, input logic [1:0] st,
                                           input logic [15:0] nid, input logic [15:0] rid,
                                           input logic rv);
        c.typed = 1;
        c.st = st;
        c.nid = nid;
        c.rid = rid;
        c.rv = rv;
        return c;
    endfunction

    // Random commands lean on the live task set so exits mostly hit; the create
    // weight swings by phase so the table both fills up and drains.
    function automatic t_cmd_row rand_row(input int n);
        t_cmd_row c;
        logic [15:0] live[$];
        int r, cw;
        for (int s = 0; s < N_SLOTS; s++) if (slot_id[s] != 0) live.push_back(slot_id[s]);
        c = mk(OP_SCHEDULE, 4'($urandom_range(0, 15)), 16'($urandom));
        cw = ((n / 120) % 2 == 0) ? 50 : 20;
        r = $urandom_range(0, 99);
        if (r < cw) c.op = OP_CREATE;
        else if (r < cw + 30) begin
            c.op = OP_EXIT;
            if (live.size() > 0 && $urandom_range(0, 9) < 8)
                c.tid = live[$urandom_range(0, live.size() - 1)];
        end else if (r < 96) c.op = OP_SCHEDULE;
        else c.op = OP_UNUSED;
        c.drain = (n % 200 == 199);
        return c;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Command side: a transfer happens when start is high and busy is low.
    always @(posedge i_clk) begin
        t_sched_res r;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !busy) begin
            sched_predict(cur, r);
            if (cur.typed) pending_q.push_back('{cur.st, cur.nid, cur.rid, cur.rv});
            else pending_q.push_back(r);
            issued++;
            start <= 1'b0;
            gap <= pick_gap();
        end else if (!start) begin
            if (gap > 0) begin
                gap <= gap - 1;
            end else if (issued < dir_rows.size() + N_RANDOM) begin
                cur = (issued < dir_rows.size()) ? dir_rows[issued]
                                                : rand_row(issued - dir_rows.size());
                if (!cur.drain || pending_q.size() == 0) begin
                    if (cur.drain) cur.drain = 0;
                    i_op <= cur.op;
                    i_prio <= cur.prio;
                    i_task_id <= cur.tid;
                    start <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_sched_res e;
        if (i_rst_n && o_done) begin
            if (pending_q.size() == 0) begin
                report("result with nothing pending");
            end else begin
                e = pending_q.pop_front();
                if (o_status !== e.st)
                    report($sformatf("status %0d, want %0d", o_status, e.st));
                if (o_new_id !== e.nid)
                    report($sformatf("new_id %0d, want %0d", o_new_id, e.nid));
                if (o_running_id !== e.rid)
                    report($sformatf("running_id %0d, want %0d", o_running_id, e.rid));
                if (o_running_valid !== e.rv)
                    report($sformatf("running_valid %0d, want %0d", o_running_valid, e.rv));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > MAX_CYC) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        sched_reset();
        dir_rows.push_back(typed_row(mk(OP_SCHEDULE, 0, 0), ST_OK, 0, 0, 0));
        dir_rows.push_back(typed_row(mk(OP_EXIT, 0, 16'h0000), ST_NOT_FOUND, 0, 0, 0));
        dir_rows.push_back(typed_row(mk(OP_UNUSED, 4'hF, 16'hFFFF), ST_OK, 0, 0, 0));
        dir_rows.push_back(typed_row(mk(OP_CREATE, 4'hF, 0), ST_OK, 16'd1, 0, 0));
        dir_rows.push_back(typed_row(mk(OP_SCHEDULE, 0, 0), ST_OK, 0, 16'd1, 1));
        for (int k = 0; k < 15; k++) dir_rows.push_back(mk(OP_CREATE, 4'(k), 0));
        dir_rows.push_back(typed_row(mk(OP_CREATE, 4'd3, 0), ST_FULL, 0, 16'd1, 1));
        dir_rows.push_back(typed_row(mk(OP_EXIT, 0, 16'hFFFF), ST_NOT_FOUND, 0, 16'd1, 1));
        dir_rows.push_back(mk(OP_EXIT, 0, 16'd1));
        dir_rows.push_back(mk(OP_SCHEDULE, 0, 0));
        dir_rows.push_back(mk(OP_EXIT, 0, 16'd9));
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (issued == dir_rows.size() + N_RANDOM && pending_q.size() == 0);
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
